@@ hdl/rde_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix digit encoder package
// Widths, radix constants and the digit alphabet shared by the encoder files.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned SYMBOL_W    = 7;
  localparam int unsigned REM_W       = 6;
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned NUM_CHUNKS  = VALUE_W / CHUNK_W;
  localparam int unsigned CHUNK_IDX_W = $clog2(NUM_CHUNKS);

  localparam logic [REM_W-1:0] RADIX_WIDE   = 6'd62;
  localparam logic [REM_W-1:0] RADIX_NARROW = 6'd36;

  localparam logic RADIX_SEL_WIDE   = 1'b0;
  localparam logic RADIX_SEL_NARROW = 1'b1;

  localparam logic [SYMBOL_W-1:0] SYM_TERMINATOR = 7'd0;

  // Alphabet: '0'..'9', then 'a'..'z', then 'A'..'Z'.
  function automatic logic [SYMBOL_W-1:0] digit_symbol(input logic [REM_W-1:0] digit);
    logic [SYMBOL_W-1:0] wide;
    wide = {1'b0, digit};
    if (digit < 6'd10) begin
      return wide + 7'd48;
    end else if (digit < 6'd36) begin
      return wide + 7'd87;
    end else begin
      return wide + 7'd29;
    end
  endfunction

endpackage

@@ hdl/rde_if.sv @@
// ----------------------------------------------------------------------------
// Radix digit encoder channels
// Valid/ready channels for the input value and the output symbols.
// ----------------------------------------------------------------------------
interface rde_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rde_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

@@ hdl/rde_div_step.sv @@
// ----------------------------------------------------------------------------
// Byte divide step
// Restoring long division of one byte by a small divisor, carrying remainder.
// ----------------------------------------------------------------------------
module rde_div_step import rde_pkg::*; (
  input  logic [REM_W-1:0]   divisor_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [CHUNK_W-1:0] chunk_i,
  output logic [CHUNK_W-1:0] quo_o,
  output logic [REM_W-1:0]   rem_o
);

  // The incoming remainder is always below the divisor, so each partial
  // value fits in one bit more than the remainder.
  always_comb begin
    logic [REM_W:0]   part;
    logic [REM_W-1:0] r;
    r     = rem_i;
    part  = '0;
    quo_o = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      part = {r, chunk_i[i]};
      if (part >= {1'b0, divisor_i}) begin
        quo_o[i] = 1'b1;
        part     = part - {1'b0, divisor_i};
      end
      r = part[REM_W-1:0];
    end
    rem_o = r;
  end

endmodule

@@ hdl/radix_digit_encoder.sv @@
// ----------------------------------------------------------------------------
// Radix digit encoder
// Converts a 64-bit unsigned value to base-62 or base-36 ASCII text.
// ----------------------------------------------------------------------------
// The block takes one 64-bit value per transfer and returns its digits as
// ASCII characters, least significant digit first, followed by a terminator
// transfer with symbol 0 and is_last set; a zero value gives the terminator
// alone. The radix_select register picks base 62 (0) or base 36 (1) and is
// read while an item is being converted. Each digit comes from a long
// division of the running quotient by the radix, done by one shared byte
// divide unit, one byte per cycle from the most significant nonzero byte
// down, so a digit costs work only for the significant bytes of the running
// quotient. The input is ready only while no conversion is in progress;
// results wait in an output register, and the division stalls on a digit
// only when that register is still full.
// ----------------------------------------------------------------------------
module radix_digit_encoder import rde_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  rde_in_if.sink            in_i,
  rde_out_if.source         out_o
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_TERM = 2'd2;

  logic [1:0]             state_q, state_d;
  logic                   radix_q, radix_d;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [CHUNK_IDX_W-1:0] idx_q, idx_d;
  logic [CHUNK_IDX_W-1:0] top_q, top_d;
  logic                   top_zero_q, top_zero_d;
  logic                   out_valid_q, out_valid_d;
  logic [SYMBOL_W-1:0]    out_sym_q, out_sym_d;
  logic                   out_last_q, out_last_d;

  logic [REM_W-1:0]       divisor;
  logic [CHUNK_W-1:0]     chunk;
  logic [CHUNK_W-1:0]     step_quo;
  logic [REM_W-1:0]       step_rem;
  logic [CHUNK_IDX_W-1:0] lead_idx;
  logic [CHUNK_IDX_W-1:0] next_top;
  logic                   in_xfer;
  logic                   out_free;
  logic                   last_chunk;
  logic                   quo_zero;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_xfer       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.symbol  = out_sym_q;
  assign out_o.is_last = out_last_q;

  // The output register can take a new result when it is empty or when its
  // current contents leave in this cycle.
  assign out_free = !out_valid_q || out_o.ready;

  assign divisor = (radix_q == RADIX_SEL_NARROW) ? RADIX_NARROW : RADIX_WIDE;

  // Most significant nonzero byte of the incoming value; the division starts
  // there so that leading zero bytes are skipped.
  always_comb begin
    lead_idx = '0;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      if (in_i.value[c*CHUNK_W +: CHUNK_W] != '0) begin
        lead_idx = CHUNK_IDX_W'(c);
      end
    end
  end

  assign chunk      = value_q[idx_q*CHUNK_W +: CHUNK_W];
  assign last_chunk = (idx_q == '0);

  rde_div_step u_div_step (
    .divisor_i (divisor),
    .rem_i     (rem_q),
    .chunk_i   (chunk),
    .quo_o     (step_quo),
    .rem_o     (step_rem)
  );

  // Dividing by a radix below 256 shortens the quotient by at most one byte.
  // The whole quotient is zero only when a single byte was left and its
  // quotient byte is zero.
  assign next_top = (top_q != '0 && top_zero_q) ? top_q - 1'b1 : top_q;
  assign quo_zero = (top_q == '0) && (step_quo == '0);

  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    value_d     = value_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    top_d       = top_q;
    top_zero_d  = top_zero_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;

    if (cfg_we_i) begin
      radix_d = cfg_wdata_i;
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          value_d    = in_i.value;
          rem_d      = '0;
          idx_d      = lead_idx;
          top_d      = lead_idx;
          top_zero_d = 1'b0;
          state_d    = (in_i.value != '0) ? S_DIV : S_TERM;
        end
      end
      S_DIV: begin
        // Only the byte that completes a digit needs room in the output.
        if (!last_chunk || out_free) begin
          value_d[idx_q*CHUNK_W +: CHUNK_W] = step_quo;
          rem_d = step_rem;
          if (idx_q == top_q) begin
            top_zero_d = (step_quo == '0);
          end
          if (!last_chunk) begin
            idx_d = idx_q - 1'b1;
          end else begin
            out_valid_d = 1'b1;
            out_sym_d   = digit_symbol(step_rem);
            out_last_d  = 1'b0;
            rem_d       = '0;
            idx_d       = next_top;
            top_d       = next_top;
            top_zero_d  = 1'b0;
            state_d     = quo_zero ? S_TERM : S_DIV;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = SYM_TERMINATOR;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_SEL_WIDE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    rem_q      <= rem_d;
    idx_q      <= idx_d;
    top_q      <= top_d;
    top_zero_q <= top_zero_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

endmodule
